/* src/rmj_pkg.sv */
`default_nettype none
package rmj_pkg;

   localparam int CSR_W = 17;
   localparam int SAT_W = 48;
   localparam logic [CSR_W-1:0] MIN_RANGE_SQ_RESET = 17'd7;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] d_range_dpx;
      logic signed [31:0] d_range_dpy;
      logic signed [31:0] d_bearing_dpx;
      logic signed [31:0] d_bearing_dpy;
      logic signed [31:0] d_rate_dpx;
      logic signed [31:0] d_rate_dpy;
      logic               range_clamped;
   } rsp_type;

   // track data after the squared range is formed
   typedef struct packed {
      logic               p_neg;
      logic               q_neg;
      logic [31:0]        pm;
      logic [31:0]        qm;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [63:0]        s;
      logic               clamped;
   } front_type;

   typedef struct packed {
      logic               p_neg;
      logic               q_neg;
      logic [31:0]        pm;
      logic [31:0]        qm;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               clamped;
      logic signed [31:0] brg_dpx;
      logic signed [31:0] brg_dpy;
   } brg_type;

   typedef struct packed {
      logic               p_neg;
      logic               q_neg;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               clamped;
      logic signed [31:0] brg_dpx;
      logic signed [31:0] brg_dpy;
      logic [31:0]        rr;
   } rng_type;

   typedef struct packed {
      logic               clamped;
      logic signed [31:0] rng_dpx;
      logic signed [31:0] rng_dpy;
      logic signed [31:0] brg_dpx;
      logic signed [31:0] brg_dpy;
      logic [16:0]        t2m;
      logic [16:0]        t3m;
      logic               t2_neg;
      logic               t3_neg;
      logic [31:0]        rr;
   } mul_type;

   typedef struct packed {
      logic               clamped;
      logic signed [31:0] rng_dpx;
      logic signed [31:0] rng_dpy;
      logic signed [31:0] brg_dpx;
      logic signed [31:0] brg_dpy;
      logic               neg_dpx;
      logic               neg_dpy;
   } rate_type;

   // sign and magnitude to saturated two's complement
   function automatic logic signed [31:0] sat32(input logic [SAT_W-1:0] mag,
                                                input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (mag >= SAT_W'(33'h0_8000_0000)) begin
            r = 32'sh8000_0000;
         end else begin
            r = $signed(~mag[31:0] + 32'd1);
         end
      end else begin
         if (mag > SAT_W'(32'h7fff_ffff)) begin
            r = 32'sh7fff_ffff;
         end else begin
            r = $signed(mag[31:0]);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/radar_measurement_jacobian_unit.sv */
// Radar measurement Jacobian for a constant-velocity track.
// req channel (valid/ready): one track state per item, pos_x, pos_y, vel_x,
// vel_y in signed Q15.16. rsp channel (valid/ready): one item per request
// with the six nonzero position partials in saturated Q15.16 and a flag that
// is set when the squared range was raised to the floor.
// csr port: csr_wr_en writes csr_wr_data into min_range_sq (17 bits, Q15.16
// units, 0 acts as 1); write it only while the block holds no items.
// Throughput: one item per cycle while the pipeline is not stalled. From
// acceptance to rsp_valid: input, square and sum stages, then the
// one-bit-per-stage units, bearing divide (26), square root (33) and range
// divide (18), three multiply stages, range-rate divide (42), output register.
// The whole pipeline moves as one: when rsp_valid is high and rsp_ready is
// low every stage holds and req_ready drops, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets min_range_sq to 7.
`default_nettype none
module radar_measurement_jacobian_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire rmj_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output rmj_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [rmj_pkg::CSR_W-1:0]       csr_wr_data
);

   localparam int FRONT_W = $bits(rmj_pkg::front_type);
   localparam int BRG_W   = $bits(rmj_pkg::brg_type);
   localparam int RNG_W   = $bits(rmj_pkg::rng_type);
   localparam int RATE_W  = $bits(rmj_pkg::rate_type);

   logic en;
   logic rsp_valid_ff;
   rmj_pkg::rsp_type rsp_data_ff;
   rmj_pkg::rsp_type rsp_data_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // floor register
   logic [rmj_pkg::CSR_W-1:0] min_sq_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_sq_ff <= rmj_pkg::MIN_RANGE_SQ_RESET;
      end else if (csr_wr_en) begin
         min_sq_ff <= csr_wr_data;
      end
   end

   // input stage
   logic             in_vld_ff;
   rmj_pkg::req_type in_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;
      end
   end

   // magnitudes and squares
   logic               sq_vld_ff;
   logic               p_neg_ff, q_neg_ff;
   logic [31:0]        pm_ff, qm_ff;
   logic signed [31:0] vx_ff, vy_ff;
   logic [63:0]        sq_p_ff, sq_q_ff;
   logic [31:0]        pm_in, qm_in;

   assign pm_in = in_ff.pos_x[31] ? ~in_ff.pos_x + 32'd1 : in_ff.pos_x;
   assign qm_in = in_ff.pos_y[31] ? ~in_ff.pos_y + 32'd1 : in_ff.pos_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else if (en) begin
         sq_vld_ff <= in_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p_neg_ff <= in_ff.pos_x[31];
         q_neg_ff <= in_ff.pos_y[31];
         pm_ff    <= pm_in;
         qm_ff    <= qm_in;
         vx_ff    <= in_ff.vel_x;
         vy_ff    <= in_ff.vel_y;
         sq_p_ff  <= 64'(pm_in) * 64'(pm_in);
         sq_q_ff  <= 64'(qm_in) * 64'(qm_in);
      end
   end

   // squared range and floor
   logic                      fr_vld_ff;
   rmj_pkg::front_type        fr_ff;
   rmj_pkg::front_type        fr_in;
   logic [63:0]               s_sum;
   logic [rmj_pkg::CSR_W-1:0] flr;
   logic [63:0]               flr_s;

   assign s_sum = sq_p_ff + sq_q_ff;
   assign flr   = (min_sq_ff == '0) ? rmj_pkg::CSR_W'(1) : min_sq_ff;
   assign flr_s = {31'd0, flr, 16'd0};

   always_comb begin
      fr_in.p_neg   = p_neg_ff;
      fr_in.q_neg   = q_neg_ff;
      fr_in.pm      = pm_ff;
      fr_in.qm      = qm_ff;
      fr_in.vx      = vx_ff;
      fr_in.vy      = vy_ff;
      fr_in.clamped = s_sum < flr_s;
      fr_in.s       = (s_sum < flr_s) ? flr_s : s_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else if (en) begin
         fr_vld_ff <= sq_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff <= fr_in;
      end
   end

   // bearing: magnitude * 2^32 / s
   logic               bd_vld;
   logic [24:0]        bd_qa, bd_qb;
   logic [FRONT_W-1:0] bd_sb_raw;
   rmj_pkg::front_type bd_sb;
   rmj_pkg::brg_type   bd_out;

   rmj_div #(
      .NUM_W (64),
      .DEN_W (64),
      .QUO_W (25),
      .SB_W  (FRONT_W)
   ) u_brg_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (fr_vld_ff),
      .num_a   ({fr_ff.qm, 32'd0}),
      .num_b   ({fr_ff.pm, 32'd0}),
      .den     (fr_ff.s),
      .sb_in   (fr_ff),
      .out_vld (bd_vld),
      .quo_a   (bd_qa),
      .quo_b   (bd_qb),
      .sb_out  (bd_sb_raw)
   );

   assign bd_sb = bd_sb_raw;

   always_comb begin
      bd_out.p_neg   = bd_sb.p_neg;
      bd_out.q_neg   = bd_sb.q_neg;
      bd_out.pm      = bd_sb.pm;
      bd_out.qm      = bd_sb.qm;
      bd_out.vx      = bd_sb.vx;
      bd_out.vy      = bd_sb.vy;
      bd_out.clamped = bd_sb.clamped;
      // minus py over squared range
      bd_out.brg_dpx = rmj_pkg::sat32(rmj_pkg::SAT_W'(bd_qa), !bd_sb.q_neg);
      bd_out.brg_dpy = rmj_pkg::sat32(rmj_pkg::SAT_W'(bd_qb), bd_sb.p_neg);
   end

   // range
   logic             sq_out_vld;
   logic [31:0]      rr;
   logic [BRG_W-1:0] sr_sb_raw;
   rmj_pkg::brg_type sr_sb;
   rmj_pkg::rng_type rg_in;

   rmj_sqrt #(
      .SB_W (BRG_W)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (bd_vld),
      .rad     (bd_sb.s),
      .sb_in   (bd_out),
      .out_vld (sq_out_vld),
      .root    (rr),
      .sb_out  (sr_sb_raw)
   );

   assign sr_sb = sr_sb_raw;

   always_comb begin
      rg_in.p_neg   = sr_sb.p_neg;
      rg_in.q_neg   = sr_sb.q_neg;
      rg_in.vx      = sr_sb.vx;
      rg_in.vy      = sr_sb.vy;
      rg_in.clamped = sr_sb.clamped;
      rg_in.brg_dpx = sr_sb.brg_dpx;
      rg_in.brg_dpy = sr_sb.brg_dpy;
      rg_in.rr      = rr;
   end

   // px/r and py/r, at most 2^16 in magnitude
   logic             rd_vld;
   logic [16:0]      rd_qa, rd_qb;
   logic [RNG_W-1:0] rd_sb_raw;
   rmj_pkg::rng_type rd_sb;

   rmj_div #(
      .NUM_W (48),
      .DEN_W (32),
      .QUO_W (17),
      .SB_W  (RNG_W)
   ) u_rng_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sq_out_vld),
      .num_a   ({sr_sb.pm, 16'd0}),
      .num_b   ({sr_sb.qm, 16'd0}),
      .den     (rr),
      .sb_in   (rg_in),
      .out_vld (rd_vld),
      .quo_a   (rd_qa),
      .quo_b   (rd_qb),
      .sb_out  (rd_sb_raw)
   );

   assign rd_sb = rd_sb_raw;

   // range-rate numerator: x = vx*t3 - vy*t2
   rmj_pkg::mul_type   m1_in;
   rmj_pkg::mul_type   m1_ff, m2_ff;
   logic               m1_vld_ff, m2_vld_ff, m3_vld_ff;
   logic signed [17:0] t2s, t3s;
   logic signed [49:0] pa_ff, pb_ff;
   logic signed [50:0] x_c;
   logic [48:0]        xm_ff;
   logic               x_neg_ff;

   assign t2s = rd_sb.p_neg ? -$signed({1'b0, rd_qa}) : $signed({1'b0, rd_qa});
   assign t3s = rd_sb.q_neg ? -$signed({1'b0, rd_qb}) : $signed({1'b0, rd_qb});

   always_comb begin
      m1_in.clamped = rd_sb.clamped;
      m1_in.rng_dpx = rmj_pkg::sat32(rmj_pkg::SAT_W'(rd_qa), rd_sb.p_neg);
      m1_in.rng_dpy = rmj_pkg::sat32(rmj_pkg::SAT_W'(rd_qb), rd_sb.q_neg);
      m1_in.brg_dpx = rd_sb.brg_dpx;
      m1_in.brg_dpy = rd_sb.brg_dpy;
      m1_in.t2m     = rd_qa;
      m1_in.t3m     = rd_qb;
      m1_in.t2_neg  = rd_sb.p_neg;
      m1_in.t3_neg  = rd_sb.q_neg;
      m1_in.rr      = rd_sb.rr;
   end

   assign x_c = 51'(pa_ff) - 51'(pb_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1_in;
         pa_ff    <= 50'(rd_sb.vx * t3s);
         pb_ff    <= 50'(rd_sb.vy * t2s);
         m2_ff    <= m1_ff;
         x_neg_ff <= x_c[50];
         xm_ff    <= x_c[50] ? 49'(-x_c) : x_c[48:0];
      end
   end

   // products for the last divide
   rmj_pkg::rate_type rt_ff;
   logic [64:0]       na_ff, nb_ff;
   logic [47:0]       rden_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff           <= 65'(m2_ff.t3m) * 65'(xm_ff);
         nb_ff           <= 65'(m2_ff.t2m) * 65'(xm_ff);
         rden_ff         <= {m2_ff.rr, 16'd0};
         rt_ff.clamped   <= m2_ff.clamped;
         rt_ff.rng_dpx   <= m2_ff.rng_dpx;
         rt_ff.rng_dpy   <= m2_ff.rng_dpy;
         rt_ff.brg_dpx   <= m2_ff.brg_dpx;
         rt_ff.brg_dpy   <= m2_ff.brg_dpy;
         rt_ff.neg_dpx   <= m2_ff.t3_neg ^ x_neg_ff;
         rt_ff.neg_dpy   <= !(m2_ff.t2_neg ^ x_neg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= rd_vld;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   // range rate over r^3
   logic              rt_vld;
   logic [40:0]       rt_qa, rt_qb;
   logic [RATE_W-1:0] rt_sb_raw;
   rmj_pkg::rate_type rt_sb;

   rmj_div #(
      .NUM_W (65),
      .DEN_W (48),
      .QUO_W (41),
      .SB_W  (RATE_W)
   ) u_rate_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (m3_vld_ff),
      .num_a   (na_ff),
      .num_b   (nb_ff),
      .den     (rden_ff),
      .sb_in   (rt_ff),
      .out_vld (rt_vld),
      .quo_a   (rt_qa),
      .quo_b   (rt_qb),
      .sb_out  (rt_sb_raw)
   );

   assign rt_sb = rt_sb_raw;

   always_comb begin
      rsp_data_in.d_range_dpx   = rt_sb.rng_dpx;
      rsp_data_in.d_range_dpy   = rt_sb.rng_dpy;
      rsp_data_in.d_bearing_dpx = rt_sb.brg_dpx;
      rsp_data_in.d_bearing_dpy = rt_sb.brg_dpy;
      rsp_data_in.d_rate_dpx    = rmj_pkg::sat32(rmj_pkg::SAT_W'(rt_qa), rt_sb.neg_dpx);
      rsp_data_in.d_rate_dpy    = rmj_pkg::sat32(rmj_pkg::SAT_W'(rt_qb), rt_sb.neg_dpy);
      rsp_data_in.range_clamped = rt_sb.clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rt_vld;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // unit-vector partials never exceed one
   a_rng_dpx_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.d_range_dpx <= 32'sd65536) &&
                    (rsp_data.d_range_dpx >= -32'sd65536))
      else $error("d_range_dpx out of unit range");

   a_rng_dpy_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.d_range_dpy <= 32'sd65536) &&
                    (rsp_data.d_range_dpy >= -32'sd65536))
      else $error("d_range_dpy out of unit range");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule
`default_nettype wire

/* src/rmj_sqrt.sv */
`default_nettype none
module rmj_sqrt #(
   parameter int SB_W = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_vld,
   input  wire logic [63:0]     rad,
   input  wire logic [SB_W-1:0] sb_in,
   output logic                 out_vld,
   output logic [31:0]          root,
   output logic [SB_W-1:0]      sb_out
);

   localparam int STEPS = 32;

   logic [63:0]     n_ff   [STEPS+1];
   logic [63:0]     res_ff [STEPS+1];
   logic [SB_W-1:0] sb_ff  [STEPS+1];
   logic            vld_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= rad;
         res_ff[0] <= '0;
         sb_ff[0]  <= sb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   // one result bit per stage, bit weight fixed by the stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam logic [63:0] BITV = 64'd1 << (64 - 2 * k);
      logic [63:0] trial;
      logic        ge;
      assign trial = res_ff[k-1] + BITV;
      assign ge    = n_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]   <= ge ? n_ff[k-1] - trial : n_ff[k-1];
            res_ff[k] <= ge ? (res_ff[k-1] >> 1) + BITV : res_ff[k-1] >> 1;
            sb_ff[k]  <= sb_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_vld = vld_ff[STEPS];
   assign root    = res_ff[STEPS][31:0];
   assign sb_out  = sb_ff[STEPS];

endmodule
`default_nettype wire

/* src/rmj_div.sv */
`default_nettype none
module rmj_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int QUO_W = 17,
   parameter int SB_W  = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_vld,
   input  wire logic [NUM_W-1:0] num_a,
   input  wire logic [NUM_W-1:0] num_b,
   input  wire logic [DEN_W-1:0] den,
   input  wire logic [SB_W-1:0]  sb_in,
   output logic                  out_vld,
   output logic [QUO_W-1:0]      quo_a,
   output logic [QUO_W-1:0]      quo_b,
   output logic [SB_W-1:0]       sb_out
);

   // two lanes share one divisor; the quotient is known to fit QUO_W bits,
   // so the bits above start out as the partial remainder
   logic [DEN_W-1:0] rem_a_ff [QUO_W+1];
   logic [DEN_W-1:0] rem_b_ff [QUO_W+1];
   logic [QUO_W-1:0] wrk_a_ff [QUO_W+1];
   logic [QUO_W-1:0] wrk_b_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff   [QUO_W+1];
   logic [SB_W-1:0]  sb_ff    [QUO_W+1];
   logic             vld_ff   [QUO_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_a_ff[0] <= DEN_W'(num_a >> QUO_W);
         rem_b_ff[0] <= DEN_W'(num_b >> QUO_W);
         wrk_a_ff[0] <= num_a[QUO_W-1:0];
         wrk_b_ff[0] <= num_b[QUO_W-1:0];
         den_ff[0]   <= den;
         sb_ff[0]    <= sb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [DEN_W:0] trial_a;
      logic [DEN_W:0] trial_b;
      logic [DEN_W:0] den_x;
      logic           ge_a;
      logic           ge_b;
      assign trial_a = {rem_a_ff[k-1], wrk_a_ff[k-1][QUO_W-1]};
      assign trial_b = {rem_b_ff[k-1], wrk_b_ff[k-1][QUO_W-1]};
      assign den_x   = {1'b0, den_ff[k-1]};
      assign ge_a    = trial_a >= den_x;
      assign ge_b    = trial_b >= den_x;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_a_ff[k] <= ge_a ? DEN_W'(trial_a - den_x) : DEN_W'(trial_a);
            rem_b_ff[k] <= ge_b ? DEN_W'(trial_b - den_x) : DEN_W'(trial_b);
            wrk_a_ff[k] <= {wrk_a_ff[k-1][QUO_W-2:0], ge_a};
            wrk_b_ff[k] <= {wrk_b_ff[k-1][QUO_W-2:0], ge_b};
            den_ff[k]   <= den_ff[k-1];
            sb_ff[k]    <= sb_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_vld = vld_ff[QUO_W];
   assign quo_a   = wrk_a_ff[QUO_W];
   assign quo_b   = wrk_b_ff[QUO_W];
   assign sb_out  = sb_ff[QUO_W];

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;

   localparam int LATENCY = 126;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rmj_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rmj_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [rmj_pkg::CSR_W-1:0] csr_wr_data = '0;

   rmj_pkg::req_type track_queue[$];
   rmj_pkg::rsp_type jacobian_queue[$];
   logic [rmj_pkg::CSR_W-1:0] floor_shadow = rmj_pkg::MIN_RANGE_SQ_RESET;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int stall_cycles = 0;

   radar_measurement_jacobian_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // truncated a*b/d as sign and magnitude, saturated to 32 bits
   function automatic logic signed [31:0] scaled_quotient(input logic [63:0] a,
         input logic neg, input logic [63:0] b, input logic [63:0] d);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = {64'd0, a} * {64'd0, b};
      quo = prod / {64'd0, d};
      if (neg) begin
         if (quo >= 128'h8000_0000) return 32'sh8000_0000;
         return $signed(-quo[31:0]);
      end
      if (quo > 128'h7fff_ffff) return 32'sh7fff_ffff;
      return $signed(quo[31:0]);
   endfunction

   function automatic rmj_pkg::rsp_type predict_jacobian(input rmj_pkg::req_type t,
         input logic [rmj_pkg::CSR_W-1:0] floor_reg);
      rmj_pkg::rsp_type r;
      logic signed [63:0] p, q, vx, vy, t2, t3;
      logic signed [65:0] x;
      logic [63:0] pm, qm, s, f, rr, xm, t2m, t3m;
      p = t.pos_x;
      q = t.pos_y;
      vx = t.vel_x;
      vy = t.vel_y;
      pm = p < 0 ? -p : p;
      qm = q < 0 ? -q : q;
      s = pm * pm + qm * qm;
      f = (floor_reg == 0 ? 64'd1 : 64'(floor_reg)) << 16;
      r.range_clamped = 1'b0;
      if (s < f) begin
         s = f;
         r.range_clamped = 1'b1;
      end
      rr = int_sqrt(s);
      r.d_range_dpx = scaled_quotient(pm, p < 0, 64'd65536, rr);
      r.d_range_dpy = scaled_quotient(qm, q < 0, 64'd65536, rr);
      r.d_bearing_dpx = scaled_quotient(qm, q > 0, 64'd1 << 32, s);
      r.d_bearing_dpy = scaled_quotient(pm, p < 0, 64'd1 << 32, s);
      t2 = r.d_range_dpx;
      t3 = r.d_range_dpy;
      x = 66'(vx) * 66'(t3) - 66'(vy) * 66'(t2);
      xm = x < 0 ? 64'(-x) : 64'(x);
      t2m = t2 < 0 ? -t2 : t2;
      t3m = t3 < 0 ? -t3 : t3;
      r.d_rate_dpx = scaled_quotient(t3m, (t3 < 0) != (x < 0) && t3 != 0 && x != 0,
                                     xm, rr << 16);
      r.d_rate_dpy = scaled_quotient(t2m, (t2 < 0) == (x < 0) && t2 != 0 && x != 0,
                                     xm, rr << 16);
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      errors++;
   endtask

   // driver: next item goes out once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) jacobian_queue.push_back(predict_jacobian(req_data, floor_shadow));
         if (track_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= track_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rmj_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         if (rsp_valid && rsp_ready) begin
            if (jacobian_queue.size() == 0) begin
               report("unexpected item", rsp_data.d_range_dpx, 32'd0);
            end else begin
               want = jacobian_queue.pop_front();
               if (rsp_data.d_range_dpx !== want.d_range_dpx)
                  report("d_range_dpx", rsp_data.d_range_dpx, want.d_range_dpx);
               if (rsp_data.d_range_dpy !== want.d_range_dpy)
                  report("d_range_dpy", rsp_data.d_range_dpy, want.d_range_dpy);
               if (rsp_data.d_bearing_dpx !== want.d_bearing_dpx)
                  report("d_bearing_dpx", rsp_data.d_bearing_dpx, want.d_bearing_dpx);
               if (rsp_data.d_bearing_dpy !== want.d_bearing_dpy)
                  report("d_bearing_dpy", rsp_data.d_bearing_dpy, want.d_bearing_dpy);
               if (rsp_data.d_rate_dpx !== want.d_rate_dpx)
                  report("d_rate_dpx", rsp_data.d_rate_dpx, want.d_rate_dpx);
               if (rsp_data.d_rate_dpy !== want.d_rate_dpy)
                  report("d_rate_dpy", rsp_data.d_rate_dpy, want.d_rate_dpy);
               if (rsp_data.range_clamped !== want.range_clamped)
                  report("range_clamped", 32'(rsp_data.range_clamped),
                         32'(want.range_clamped));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (track_queue.size() == 0 && jacobian_queue.size() == 0 && !req_valid)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic logic [31:0] random_coord();
      logic [31:0] v;
      case ($urandom_range(4))
         0: v = $urandom;
         1: v = $signed($urandom) >>> $urandom_range(31);
         2: v = $urandom_range(1200) - 600;
         3: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: v = $signed($urandom) >>> $urandom_range(24, 8);
      endcase
      return v;
   endfunction

   function automatic rmj_pkg::req_type random_track();
      rmj_pkg::req_type t;
      t.pos_x = random_coord();
      t.pos_y = random_coord();
      t.vel_x = random_coord();
      t.vel_y = random_coord();
      return t;
   endfunction

   task automatic add_track(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] vx, input logic [31:0] vy);
      track_queue.push_back(rmj_pkg::req_type'{px, py, vx, vy});
   endtask

   task automatic drain();
      while (track_queue.size() > 0 || req_valid || jacobian_queue.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      logic [rmj_pkg::CSR_W-1:0] floors[6];
      floors = '{rmj_pkg::MIN_RANGE_SQ_RESET, 17'd1, 17'd65536, 17'd0, 17'd131071, 17'd0};
      floors[5] = rmj_pkg::CSR_W'($urandom_range(65536, 1));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: origin, extremes, near the floor, axes
      add_track(0, 0, 0, 0);
      add_track(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_track(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_track(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      add_track(32'h8000_0000, 0, 32'h7fff_ffff, 0);
      add_track(0, 32'h7fff_ffff, 0, 32'h8000_0000);
      add_track(1, 0, 32'h0001_0000, 0);
      add_track(0, -1, 0, 32'h0001_0000);
      add_track(2, 1, 32'hffff_0000, 32'h0002_0000);
      add_track(32'h0001_0000, 0, 0, 32'h0001_0000);
      add_track(0, 32'h0001_0000, 32'h0001_0000, 0);
      add_track(32'h0000_0100, 32'h0000_0100, 32'h0010_0000, -32'sh0010_0000);
      add_track(32'h0000_b505, 0, 32'h7fff_ffff, 32'h8000_0000);
      add_track(-32'sh0003_0000, 32'h0004_0000, 32'h0001_8000, -32'sh0002_0000);
      add_track(1, 1, 32'h7fff_ffff, 32'h8000_0000);
      add_track(-1, 1, 32'h8000_0000, 32'h8000_0000);
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            drain();
            @(posedge clock);
            csr_wr_en <= 1'b1;
            csr_wr_data <= floors[ph];
            floor_shadow = floors[ph];
            @(posedge clock);
            csr_wr_en <= 1'b0;
         end
         case (ph / 2)
            0: begin send_idle_pct = 19; recv_idle_pct = 61; end
            1: begin send_idle_pct = 61; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int i = 0; i < 240; i++) track_queue.push_back(random_track());
         // in phase 1, once half the tracks have gone out, hold the sender until everything has come back
         while (track_queue.size() > 120) @(posedge clock);
         if (ph == 1) begin
            send_idle_pct = 100;
            while (jacobian_queue.size() > 0 || req_valid) @(posedge clock);
            send_idle_pct = 19;
         end
      end
      drain();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
src/rmj_pkg.sv
src/rmj_sqrt.sv
src/rmj_div.sv
src/radar_measurement_jacobian_unit.sv
tb/testbench.sv
